// ----- rtl/maze_backtracker_generator_defines.svh -----
// Assertion helpers for the maze carver.
`ifndef MAZE_BACKTRACKER_GENERATOR_DEFINES_SVH
`define MAZE_BACKTRACKER_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define MBG_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define MBG_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mbg_pkg.sv -----
package mbg_pkg;

  localparam int ROWS       = 32;
  localparam int COLS       = 32;
  localparam int CELL_COUNT = ROWS * COLS;

  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int CELL_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int DEP_W  = $clog2(CELL_COUNT + 1);

  localparam int IN_ROW_W  = 5;
  localparam int IN_COL_W  = 5;
  localparam int RND_W     = 15;
  localparam int OUT_ROW_W = 6;
  localparam int OUT_COL_W = 5;

  localparam int SLOT_N = 8;
  localparam int SLOT_W = 3;
  localparam int CNT_W  = 4;

  // Remainder unit: one 4-bit digit of the random value per cycle.
  localparam int MOD_DIG_BITS = 4;
  localparam int MOD_DIGITS   = (RND_W + MOD_DIG_BITS - 1) / MOD_DIG_BITS;
  localparam int DVD_W        = MOD_DIGITS * MOD_DIG_BITS;
  localparam int MOD_CNT_W    = (MOD_DIGITS > 1) ? $clog2(MOD_DIGITS) : 1;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef enum logic [1:0] {
    DIR_UP,
    DIR_LEFT,
    DIR_DOWN,
    DIR_RIGHT
  } dir_t;

  // Neighbor list order: up, left, up, down, left, right, right, down.
  localparam dir_t SLOT_DIR [SLOT_N] = '{DIR_UP, DIR_LEFT, DIR_UP, DIR_DOWN,
                                          DIR_LEFT, DIR_RIGHT, DIR_RIGHT, DIR_DOWN};

  typedef logic [SLOT_N-1:0] slot_mask_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    slot_mask_t       mask;
  } frame_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_START_PUSH,
    ST_MOD,
    ST_PICK,
    ST_CHECK,
    ST_POP_CHK,
    ST_POP_WAIT,
    ST_DONE
  } mbg_state_t;

  typedef struct packed {
    logic load_in;
    logic mod_start;
    logic clear_step;
    logic start_push;
    logic pick;
    logic check;
    logic pop;
    logic pop_load;
  } mbg_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic mod_done;
    logic depth_zero;
    logic depth_one;
    logic top_empty;
  } mbg_stat_t;

  function automatic logic dir_ok(input logic [ROW_W-1:0] row,
                                  input logic [COL_W-1:0] col,
                                  input dir_t d);
    logic ok;
    case (d)
      DIR_UP:   ok = (row != '0);
      DIR_LEFT: ok = (col != '0);
      DIR_DOWN: ok = (int'(row) + 1 < ROWS);
      default:  ok = (int'(col) + 1 < COLS);
    endcase
    return ok;
  endfunction

  function automatic slot_mask_t neighbor_mask(input logic [ROW_W-1:0] row,
                                               input logic [COL_W-1:0] col);
    slot_mask_t m;
    m = '0;
    for (int s = 0; s < SLOT_N; s++) begin
      m[s] = dir_ok(row, col, SLOT_DIR[s]);
    end
    return m;
  endfunction

  function automatic logic [CNT_W-1:0] mask_count(input slot_mask_t m);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int s = 0; s < SLOT_N; s++) begin
      n = n + CNT_W'(m[s]);
    end
    return n;
  endfunction

  // Slot of the k-th set bit, counting from the low end.
  function automatic logic [SLOT_W-1:0] pick_slot(input slot_mask_t m,
                                                  input logic [SLOT_W-1:0] k);
    logic [SLOT_W:0]   seen;
    logic [SLOT_W-1:0] slot;
    logic              found;
    seen  = '0;
    slot  = '0;
    found = 1'b0;
    for (int s = 0; s < SLOT_N; s++) begin
      if (m[s] && !found) begin
        if (seen == {1'b0, k}) begin
          found = 1'b1;
          slot  = SLOT_W'(s);
        end else begin
          seen = seen + 1'b1;
        end
      end
    end
    return slot;
  endfunction

  function automatic logic [ROW_W-1:0] sat_row(input logic [IN_ROW_W-1:0] v);
    logic [ROW_W-1:0] r;
    if (int'(v) >= ROWS) r = ROW_W'(ROWS - 1);
    else r = ROW_W'(v);
    return r;
  endfunction

  function automatic logic [COL_W-1:0] sat_col(input logic [IN_COL_W-1:0] v);
    logic [COL_W-1:0] c;
    if (int'(v) >= COLS) c = COL_W'(COLS - 1);
    else c = COL_W'(v);
    return c;
  endfunction

  function automatic logic [CELL_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return CELL_W'(int'(row) * COLS + int'(col));
  endfunction

endpackage

// ----- rtl/mbg_mod_unit.sv -----
// Remainder of a 15-bit value by a count of 1 to 8, one 4-bit digit per cycle.
module mbg_mod_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [mbg_pkg::RND_W-1:0]  dividend,
  input  logic [mbg_pkg::CNT_W-1:0]  divisor,
  output logic                       done,
  output logic [mbg_pkg::SLOT_W-1:0] remainder
);

  logic [mbg_pkg::DVD_W-1:0]     dvd_r;
  logic [mbg_pkg::CNT_W-1:0]     div_r;
  logic [mbg_pkg::SLOT_W-1:0]    rem_r;
  logic [mbg_pkg::SLOT_W-1:0]    rem_nxt;
  logic [mbg_pkg::MOD_CNT_W-1:0] cnt_r;
  logic                          run_r;
  logic                          done_r;

  always_comb begin
    logic [mbg_pkg::CNT_W-1:0] part;
    rem_nxt = rem_r;
    part    = '0;
    for (int i = 0; i < mbg_pkg::MOD_DIG_BITS; i++) begin
      part = {rem_nxt, dvd_r[mbg_pkg::DVD_W-1-i]};
      if (part >= div_r) part = part - div_r;
      rem_nxt = part[mbg_pkg::SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == mbg_pkg::MOD_CNT_W'(mbg_pkg::MOD_DIGITS - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= mbg_pkg::DVD_W'(dividend);
      div_r <= divisor;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (run_r) begin
      dvd_r <= dvd_r << mbg_pkg::MOD_DIG_BITS;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// ----- rtl/mbg_datapath.sv -----
// Visited map, frame stack with cached top frame, neighbor pick and wall result.
module mbg_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [mbg_pkg::IN_ROW_W-1:0]  in_start_row,
  input  logic [mbg_pkg::IN_COL_W-1:0]  in_start_col,
  input  logic [mbg_pkg::RND_W-1:0]     in_random_value,
  input  mbg_pkg::mbg_cmd_t             cmd,
  output mbg_pkg::mbg_stat_t            stat,
  output logic                          out_carved,
  output logic [mbg_pkg::OUT_ROW_W-1:0] out_wall_row,
  output logic [mbg_pkg::OUT_COL_W-1:0] out_wall_col,
  output logic                          out_finished
);

  logic                      vis_mem [mbg_pkg::CELL_COUNT];
  mbg_pkg::frame_t           stk_mem [mbg_pkg::CELL_COUNT];

  mbg_pkg::frame_t           top_r;
  mbg_pkg::frame_t           stk_rd_r;
  logic [mbg_pkg::DEP_W-1:0] depth_r;
  logic [mbg_pkg::DEP_W-1:0] depth_m1;
  logic [mbg_pkg::DEP_W-1:0] depth_m2;
  logic [mbg_pkg::ROW_W-1:0] srow_r;
  logic [mbg_pkg::COL_W-1:0] scol_r;
  logic [mbg_pkg::CELL_W-1:0] clr_addr_r;
  logic [mbg_pkg::ROW_W-1:0] nbr_row_r;
  logic [mbg_pkg::COL_W-1:0] nbr_col_r;
  logic [mbg_pkg::CELL_W-1:0] nbr_addr_r;
  logic                      vis_rd_r;
  logic                      carved_r;
  logic [mbg_pkg::OUT_ROW_W-1:0] wall_row_r;
  logic [mbg_pkg::OUT_COL_W-1:0] wall_col_r;

  logic                       mod_done;
  logic [mbg_pkg::SLOT_W-1:0] mod_rem;
  logic [mbg_pkg::SLOT_W-1:0] slot;
  logic [mbg_pkg::ROW_W-1:0]  nbr_row;
  logic [mbg_pkg::COL_W-1:0]  nbr_col;
  logic [mbg_pkg::CELL_W-1:0] nbr_addr;
  logic                       carve;
  logic                       vis_we;
  logic [mbg_pkg::CELL_W-1:0] vis_waddr;
  logic [mbg_pkg::ROW_W-1:0]  min_row;
  logic [mbg_pkg::ROW_W:0]    wall_row_full;
  logic [mbg_pkg::COL_W-1:0]  max_col;

  mbg_mod_unit u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.mod_start),
    .dividend  (in_random_value),
    .divisor   (mbg_pkg::mask_count(top_r.mask)),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // Neighbor chosen by the remainder.
  always_comb begin
    slot    = mbg_pkg::pick_slot(top_r.mask, mod_rem);
    nbr_row = top_r.row;
    nbr_col = top_r.col;
    case (mbg_pkg::SLOT_DIR[slot])
      mbg_pkg::DIR_UP:   nbr_row = top_r.row - 1'b1;
      mbg_pkg::DIR_LEFT: nbr_col = top_r.col - 1'b1;
      mbg_pkg::DIR_DOWN: nbr_row = top_r.row + 1'b1;
      default:           nbr_col = top_r.col + 1'b1;
    endcase
    nbr_addr = mbg_pkg::cell_addr(nbr_row, nbr_col);
  end

  assign carve    = cmd.check && !vis_rd_r;
  assign depth_m1 = depth_r - mbg_pkg::DEP_W'(1);
  assign depth_m2 = depth_r - mbg_pkg::DEP_W'(2);

  // Wall between the old top cell and the picked neighbor.
  always_comb begin
    min_row       = (nbr_row_r < top_r.row) ? nbr_row_r : top_r.row;
    wall_row_full = {min_row, (nbr_row_r != top_r.row)};
    max_col       = (nbr_col_r > top_r.col) ? nbr_col_r : top_r.col;
  end

  always_comb begin
    vis_we    = cmd.clear_step || cmd.start_push || carve;
    vis_waddr = nbr_addr_r;
    if (cmd.clear_step) vis_waddr = clr_addr_r;
    else if (cmd.start_push) vis_waddr = mbg_pkg::cell_addr(srow_r, scol_r);
  end

  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_waddr] <= !cmd.clear_step;
    if (cmd.pick) vis_rd_r <= vis_mem[nbr_addr];
  end

  always_ff @(posedge clk) begin
    if (carve) stk_mem[depth_m1[mbg_pkg::CELL_W-1:0]] <= top_r;
    if (cmd.pop) stk_rd_r <= stk_mem[depth_m2[mbg_pkg::CELL_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else if (cmd.start_push) begin
      depth_r <= mbg_pkg::DEP_W'(1);
    end else if (carve) begin
      depth_r <= depth_r + 1'b1;
    end else if (cmd.pop) begin
      depth_r <= depth_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_push) begin
      top_r <= '{row: srow_r, col: scol_r, mask: mbg_pkg::neighbor_mask(srow_r, scol_r)};
    end else if (cmd.pick) begin
      top_r.mask <= top_r.mask & ~(mbg_pkg::slot_mask_t'(1) << slot);
    end else if (carve) begin
      top_r <= '{row: nbr_row_r, col: nbr_col_r,
                 mask: mbg_pkg::neighbor_mask(nbr_row_r, nbr_col_r)};
    end else if (cmd.pop_load) begin
      top_r <= stk_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      srow_r     <= mbg_pkg::sat_row(in_start_row);
      scol_r     <= mbg_pkg::sat_col(in_start_col);
      clr_addr_r <= '0;
      carved_r   <= 1'b0;
      wall_row_r <= '0;
      wall_col_r <= '0;
    end else begin
      if (cmd.clear_step) clr_addr_r <= clr_addr_r + 1'b1;
      if (carve) begin
        carved_r   <= 1'b1;
        wall_row_r <= mbg_pkg::OUT_ROW_W'(wall_row_full);
        wall_col_r <= mbg_pkg::OUT_COL_W'(max_col);
      end
    end
    if (cmd.pick) begin
      nbr_row_r  <= nbr_row;
      nbr_col_r  <= nbr_col;
      nbr_addr_r <= nbr_addr;
    end
  end

  always_comb begin
    stat.clr_last   = (clr_addr_r == mbg_pkg::CELL_W'(mbg_pkg::CELL_COUNT - 1));
    stat.mod_done   = mod_done;
    stat.depth_zero = (depth_r == '0);
    stat.depth_one  = (depth_r == mbg_pkg::DEP_W'(1));
    stat.top_empty  = (top_r.mask == '0);
  end

  assign out_carved   = carved_r;
  assign out_wall_row = wall_row_r;
  assign out_wall_col = wall_col_r;
  assign out_finished = (depth_r == '0);

endmodule

// ----- rtl/mbg_ctrl.sv -----
// Sequencer for start and step items.
module mbg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_operation,
  input  mbg_pkg::mbg_stat_t  stat,
  output mbg_pkg::mbg_cmd_t   cmd,
  output logic                busy,
  output logic                out_valid
);

  mbg_pkg::mbg_state_t state_r;
  mbg_pkg::mbg_state_t state_nxt;
  logic                accept;

  assign accept = start && (state_r == mbg_pkg::ST_IDLE || state_r == mbg_pkg::ST_DONE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mbg_pkg::ST_IDLE, mbg_pkg::ST_DONE: begin
        if (!start) state_nxt = mbg_pkg::ST_IDLE;
        else if (in_operation == mbg_pkg::OP_START) state_nxt = mbg_pkg::ST_CLEAR;
        else if (stat.depth_zero) state_nxt = mbg_pkg::ST_DONE;
        else state_nxt = mbg_pkg::ST_MOD;
      end
      mbg_pkg::ST_CLEAR: begin
        if (stat.clr_last) state_nxt = mbg_pkg::ST_START_PUSH;
      end
      mbg_pkg::ST_START_PUSH: state_nxt = mbg_pkg::ST_POP_CHK;
      mbg_pkg::ST_MOD: begin
        if (stat.mod_done) state_nxt = mbg_pkg::ST_PICK;
      end
      mbg_pkg::ST_PICK:  state_nxt = mbg_pkg::ST_CHECK;
      mbg_pkg::ST_CHECK: state_nxt = mbg_pkg::ST_POP_CHK;
      mbg_pkg::ST_POP_CHK: begin
        if (!stat.depth_zero && stat.top_empty && !stat.depth_one) begin
          state_nxt = mbg_pkg::ST_POP_WAIT;
        end else begin
          state_nxt = mbg_pkg::ST_DONE;
        end
      end
      mbg_pkg::ST_POP_WAIT: state_nxt = mbg_pkg::ST_POP_CHK;
      default: state_nxt = mbg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.load_in    = accept;
    cmd.mod_start  = accept && in_operation == mbg_pkg::OP_STEP && !stat.depth_zero;
    cmd.clear_step = (state_r == mbg_pkg::ST_CLEAR);
    cmd.start_push = (state_r == mbg_pkg::ST_START_PUSH);
    cmd.pick       = (state_r == mbg_pkg::ST_PICK);
    cmd.check      = (state_r == mbg_pkg::ST_CHECK);
    cmd.pop        = (state_r == mbg_pkg::ST_POP_CHK) && !stat.depth_zero && stat.top_empty;
    cmd.pop_load   = (state_r == mbg_pkg::ST_POP_WAIT);
    busy           = !(state_r == mbg_pkg::ST_IDLE || state_r == mbg_pkg::ST_DONE);
    out_valid      = (state_r == mbg_pkg::ST_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= mbg_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

endmodule

// ----- rtl/maze_backtracker_generator.sv -----
// Randomized depth-first maze carver over a 32 by 32 grid. Every transfer in
// (start high while busy is low) yields exactly one result, shown for a single
// cycle with out_valid high; the receiver cannot stall, so sample the result
// fields in that cycle. busy is low again in the cycle that shows the result,
// so the next item may follow at once. A start item (in_operation 0) sweeps
// the visited map clear one cell per cycle, then pushes the start cell and
// shows its result. A step item (in_operation 1) runs the digit-serial
// remainder unit over the four 4-bit digits of the random value, then one
// state picks the neighbor and issues the visited-map read, one carves and
// pushes, one looks at the top frame and one shows the result. Each pop
// that leaves frames behind costs a wait state for a registered read of the
// stack memory; popping the last frame off the stack needs no wait. A step
// on an empty stack answers in the next cycle with finished high.
`include "maze_backtracker_generator_defines.svh"

module maze_backtracker_generator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_operation,
  input  logic [mbg_pkg::IN_ROW_W-1:0]  in_start_row,
  input  logic [mbg_pkg::IN_COL_W-1:0]  in_start_col,
  input  logic [mbg_pkg::RND_W-1:0]     in_random_value,
  output logic                          out_valid,
  output logic                          out_carved,
  output logic [mbg_pkg::OUT_ROW_W-1:0] out_wall_row,
  output logic [mbg_pkg::OUT_COL_W-1:0] out_wall_col,
  output logic                          out_finished
);

  // Commands down to the datapath, status back up to the sequencer.
  mbg_pkg::mbg_cmd_t  cmd;
  mbg_pkg::mbg_stat_t stat;

  // Sequence clear sweep, remainder, pick, carve and pop loop.
  mbg_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .stat         (stat),
    .cmd          (cmd),
    .busy         (busy),
    .out_valid    (out_valid)
  );

  // Hold the visited map, the frame stack and the result registers.
  mbg_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_start_row    (in_start_row),
    .in_start_col    (in_start_col),
    .in_random_value (in_random_value),
    .cmd             (cmd),
    .stat            (stat),
    .out_carved      (out_carved),
    .out_wall_row    (out_wall_row),
    .out_wall_col    (out_wall_col),
    .out_finished    (out_finished)
  );

  // A transfer either starts work or is answered in the very next cycle.
  `MBG_ASSERT_NXT(a_accept_progress, clk, rst_n, start && !busy, busy || out_valid, "transfer dropped")
  // A carve pushes a frame, so the maze cannot be finished in the same result.
  `MBG_ASSERT_IMP(a_carve_not_done, clk, rst_n, out_valid && out_carved, !out_finished, "carve with empty stack")
  // The remainder only completes while a step is in work.
  `MBG_ASSERT_IMP(a_mod_in_work, clk, rst_n, stat.mod_done, busy, "remainder outside a step")
  // Never pop an empty stack.
  `MBG_ASSERT_IMP(a_pop_nonempty, clk, rst_n, cmd.pop, !stat.depth_zero, "pop of empty stack")

endmodule
